// ----- hdl/mft_pkg.sv -----
package mft_pkg;

   localparam int CAL_FRAMES     = 50;
   localparam int CHASSIS_MOTORS = 4;
   localparam int NUM_SLOTS      = CHASSIS_MOTORS + 6;
   localparam int ADDR_W         = $clog2(NUM_SLOTS);
   localparam int SLOT_W         = 4;
   localparam int ID_W           = 11;
   localparam int CNT_W          = 6;
   localparam int ANGLE_W        = 16;
   localparam int TURN_W         = 16;
   localparam int TOTAL_W        = 30;
   localparam int TURN_SHIFT     = 13;
   localparam int WRAP_LIMIT     = 4096;

   localparam logic [ID_W-1:0] CHASSIS_BASE_RST = 11'd513;
   localparam logic [ID_W-1:0] LIFT_A_RST       = 11'd517;
   localparam logic [ID_W-1:0] LIFT_B_RST       = 11'd518;
   localparam logic [ID_W-1:0] GRAB_A_RST       = 11'd513;
   localparam logic [ID_W-1:0] GRAB_B_RST       = 11'd514;
   localparam logic [ID_W-1:0] YAW_RST          = 11'd517;
   localparam logic [ID_W-1:0] PITCH_RST        = 11'd518;

   localparam logic [ADDR_W-1:0] SLOT_LIFT_A = ADDR_W'(CHASSIS_MOTORS);
   localparam logic [ADDR_W-1:0] SLOT_LIFT_B = ADDR_W'(CHASSIS_MOTORS + 1);
   localparam logic [ADDR_W-1:0] SLOT_GRAB_A = ADDR_W'(CHASSIS_MOTORS + 2);
   localparam logic [ADDR_W-1:0] SLOT_GRAB_B = ADDR_W'(CHASSIS_MOTORS + 3);
   localparam logic [ADDR_W-1:0] SLOT_YAW    = ADDR_W'(CHASSIS_MOTORS + 4);
   localparam logic [ADDR_W-1:0] SLOT_PITCH  = ADDR_W'(CHASSIS_MOTORS + 5);

   typedef enum logic [2:0] {
      CSR_CHASSIS_BASE = 3'd0,
      CSR_LIFT_A       = 3'd1,
      CSR_LIFT_B       = 3'd2,
      CSR_GRAB_A       = 3'd3,
      CSR_GRAB_B       = 3'd4,
      CSR_YAW          = 3'd5,
      CSR_PITCH        = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [CNT_W-1:0]   count;
      logic [ANGLE_W-1:0] prev_angle;
      logic [TURN_W-1:0]  turns;
      logic [ANGLE_W-1:0] offset;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic              hit;
      logic [ADDR_W-1:0] slot;
   } route_type;

   typedef struct packed {
      logic                      calibrating;
      logic [TURN_W-1:0]         turns;
      logic signed [TOTAL_W-1:0] net_angle;
   } update_type;

endpackage

// ----- hdl/mft_if.sv -----
interface mft_req_if;
   logic               valid;
   logic               ready;
   logic               bus;
   logic [10:0]        frame_id;
   logic [15:0]        angle_raw;
   logic signed [15:0] speed_raw;
   logic [15:0]        current_raw;
   logic [7:0]         hall_byte;

   modport source (output valid, output bus, output frame_id, output angle_raw,
                   output speed_raw, output current_raw, output hall_byte,
                   input ready);
   modport sink (input valid, input bus, input frame_id, input angle_raw,
                 input speed_raw, input current_raw, input hall_byte,
                 output ready);
endinterface

interface mft_rsp_if;
   logic               valid;
   logic               ready;
   logic [3:0]         slot;
   logic               calibrating;
   logic [15:0]        angle;
   logic signed [15:0] speed;
   logic [15:0]        current;
   logic [7:0]         hall;
   logic signed [15:0] turns;
   logic signed [29:0] net_angle;

   modport source (output valid, output slot, output calibrating, output angle,
                   output speed, output current, output hall, output turns,
                   output net_angle, input ready);
   modport sink (input valid, input slot, input calibrating, input angle,
                 input speed, input current, input hall, input turns,
                 input net_angle, output ready);
endinterface

// ----- hdl/mft_ram.sv -----
module mft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/mft_router.sv -----
module mft_router (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [2:0]                 csr_index,
   input  logic [mft_pkg::ID_W-1:0]   csr_wr_data,
   input  logic                       bus,
   input  logic [mft_pkg::ID_W-1:0]   frame_id,
   output mft_pkg::route_type         route
);

   logic [mft_pkg::ID_W-1:0] base_ff, lift_a_ff, lift_b_ff;
   logic [mft_pkg::ID_W-1:0] grab_a_ff, grab_b_ff, yaw_ff, pitch_ff;
   logic [mft_pkg::ID_W:0]   diff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= mft_pkg::CHASSIS_BASE_RST;
         lift_a_ff <= mft_pkg::LIFT_A_RST;
         lift_b_ff <= mft_pkg::LIFT_B_RST;
         grab_a_ff <= mft_pkg::GRAB_A_RST;
         grab_b_ff <= mft_pkg::GRAB_B_RST;
         yaw_ff    <= mft_pkg::YAW_RST;
         pitch_ff  <= mft_pkg::PITCH_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            mft_pkg::CSR_CHASSIS_BASE: base_ff   <= csr_wr_data;
            mft_pkg::CSR_LIFT_A:       lift_a_ff <= csr_wr_data;
            mft_pkg::CSR_LIFT_B:       lift_b_ff <= csr_wr_data;
            mft_pkg::CSR_GRAB_A:       grab_a_ff <= csr_wr_data;
            mft_pkg::CSR_GRAB_B:       grab_b_ff <= csr_wr_data;
            mft_pkg::CSR_YAW:          yaw_ff    <= csr_wr_data;
            mft_pkg::CSR_PITCH:        pitch_ff  <= csr_wr_data;
            default: ;
         endcase
      end
   end

   assign diff = {1'b0, frame_id} - {1'b0, base_ff};

   // Priority follows the listed order; the chassis range wins over lift ids.
   always_comb begin
      route.hit  = 1'b0;
      route.slot = '0;
      if (!bus) begin
         if (!diff[mft_pkg::ID_W] &&
             diff[mft_pkg::ID_W-1:0] < mft_pkg::ID_W'(mft_pkg::CHASSIS_MOTORS)) begin
            route.hit  = 1'b1;
            route.slot = diff[mft_pkg::ADDR_W-1:0];
         end else if (frame_id == lift_a_ff) begin
            route.hit  = 1'b1;
            route.slot = mft_pkg::SLOT_LIFT_A;
         end else if (frame_id == lift_b_ff) begin
            route.hit  = 1'b1;
            route.slot = mft_pkg::SLOT_LIFT_B;
         end
      end else begin
         if (frame_id == grab_a_ff) begin
            route.hit  = 1'b1;
            route.slot = mft_pkg::SLOT_GRAB_A;
         end else if (frame_id == grab_b_ff) begin
            route.hit  = 1'b1;
            route.slot = mft_pkg::SLOT_GRAB_B;
         end else if (frame_id == yaw_ff) begin
            route.hit  = 1'b1;
            route.slot = mft_pkg::SLOT_YAW;
         end else if (frame_id == pitch_ff) begin
            route.hit  = 1'b1;
            route.slot = mft_pkg::SLOT_PITCH;
         end
      end
   end

endmodule

// ----- hdl/mft_update.sv -----
module mft_update (
   input  mft_pkg::entry_type              entry,
   input  logic [mft_pkg::ANGLE_W-1:0]     angle,
   output mft_pkg::entry_type              entry_next,
   output mft_pkg::update_type             upd
);

   logic signed [mft_pkg::ANGLE_W:0] step;
   logic [mft_pkg::TURN_W-1:0]       turns_new;
   logic                             calibrating;

   assign calibrating = entry.count <= mft_pkg::CNT_W'(mft_pkg::CAL_FRAMES);
   assign step = $signed({1'b0, angle}) - $signed({1'b0, entry.prev_angle});

   // A large forward step means the encoder wrapped backward, and vice versa.
   always_comb begin
      turns_new = entry.turns;
      if (step > (mft_pkg::ANGLE_W+1)'(mft_pkg::WRAP_LIMIT)) begin
         turns_new = entry.turns - 1'b1;
      end else if (step < -(mft_pkg::ANGLE_W+1)'(mft_pkg::WRAP_LIMIT)) begin
         turns_new = entry.turns + 1'b1;
      end
   end

   always_comb begin
      entry_next            = entry;
      entry_next.prev_angle = angle;
      upd.calibrating       = calibrating;
      if (calibrating) begin
         entry_next.count  = entry.count + 1'b1;
         entry_next.offset = angle;
         upd.turns         = entry.turns;
         upd.net_angle     = '0;
      end else begin
         entry_next.turns = turns_new;
         upd.turns        = turns_new;
         upd.net_angle    = $signed({turns_new[mft_pkg::TURN_W-1], turns_new,
                                     mft_pkg::TURN_SHIFT'(0)})
                            + $signed({14'd0, angle})
                            - $signed({14'd0, entry.offset});
      end
   end

endmodule

// ----- hdl/motor_feedback_multiturn_tracker.sv -----
// Routes each received motor feedback frame to one of ten motor slots and keeps a
// per-slot multi-turn angle. Slot state sits in one small RAM; a frame is read in
// the cycle it is accepted, and updated and written back when the result register
// is free, with the result beat registered in that same cycle. A frame is accepted every
// cycle while results are taken; two frames in a row to the same slot are served
// by forwarding the written entry. Frames that match no slot give no result.
// The first 51 frames of a slot only capture its zero offset and report zero
// speed, current, hall and net angle.
module motor_feedback_multiturn_tracker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [2:0]               csr_index,
   input  logic [10:0]              csr_wr_data,
   mft_req_if.sink                  req_chan,
   mft_rsp_if.source                rsp_chan
);

   mft_pkg::route_type  route;
   mft_pkg::entry_type  entry, entry_next, ram_rd_entry, fwd_entry_ff;
   mft_pkg::update_type upd;

   logic                           s1_valid_ff, s1_valid_in;
   logic [mft_pkg::ADDR_W-1:0]     s1_slot_ff;
   logic [15:0]                    s1_angle_ff, s1_current_ff;
   logic signed [15:0]             s1_speed_ff;
   logic [7:0]                     s1_hall_ff;
   logic                           fwd_ff, fwd_in;
   logic [mft_pkg::NUM_SLOTS-1:0]  entry_valid_ff;
   logic                           out_free, s1_adv, accept;
   logic [mft_pkg::ENTRY_W-1:0]    ram_rd_data;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [3:0]                     rsp_slot_ff;
   logic                           rsp_cal_ff;
   logic [15:0]                    rsp_angle_ff, rsp_current_ff;
   logic signed [15:0]             rsp_speed_ff, rsp_turns_ff;
   logic [7:0]                     rsp_hall_ff;
   logic signed [29:0]             rsp_total_ff;

   mft_router u_router (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .bus         (req_chan.bus),
      .frame_id    (req_chan.frame_id),
      .route       (route)
   );

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign s1_adv         = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign accept         = req_chan.valid && req_chan.ready;

   mft_ram #(
      .WIDTH (mft_pkg::ENTRY_W),
      .DEPTH (mft_pkg::NUM_SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_slot_ff),
      .wr_data (entry_next),
      .rd_en   (accept),
      .rd_addr (route.slot),
      .rd_data (ram_rd_data)
   );

   assign ram_rd_entry = ram_rd_data;

   // The RAM read issued alongside a write to the same slot returns stale data.
   always_comb begin
      if (fwd_ff) begin
         entry = fwd_entry_ff;
      end else if (entry_valid_ff[s1_slot_ff]) begin
         entry = ram_rd_entry;
      end else begin
         entry = '0;
      end
   end

   mft_update u_update (
      .entry      (entry),
      .angle      (s1_angle_ff),
      .entry_next (entry_next),
      .upd        (upd)
   );

   assign s1_valid_in  = accept ? route.hit : (s1_valid_ff && !s1_adv);
   assign fwd_in       = s1_adv && (s1_slot_ff == route.slot);
   assign rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         entry_valid_ff <= '0;
         fwd_ff         <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            fwd_ff <= fwd_in;
         end
         if (s1_adv) begin
            entry_valid_ff[s1_slot_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_slot_ff    <= route.slot;
         s1_angle_ff   <= req_chan.angle_raw;
         s1_speed_ff   <= req_chan.speed_raw;
         s1_current_ff <= req_chan.current_raw;
         s1_hall_ff    <= req_chan.hall_byte;
         fwd_entry_ff  <= entry_next;
      end
      if (s1_adv) begin
         rsp_slot_ff    <= 4'(s1_slot_ff);
         rsp_cal_ff     <= upd.calibrating;
         rsp_angle_ff   <= s1_angle_ff;
         rsp_speed_ff   <= upd.calibrating ? 16'sd0 : s1_speed_ff;
         rsp_current_ff <= upd.calibrating ? 16'd0 : s1_current_ff;
         rsp_hall_ff    <= upd.calibrating ? 8'd0 : s1_hall_ff;
         rsp_turns_ff   <= $signed(upd.turns);
         rsp_total_ff   <= upd.net_angle;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.slot        = rsp_slot_ff;
   assign rsp_chan.calibrating = rsp_cal_ff;
   assign rsp_chan.angle       = rsp_angle_ff;
   assign rsp_chan.speed       = rsp_speed_ff;
   assign rsp_chan.current     = rsp_current_ff;
   assign rsp_chan.hall        = rsp_hall_ff;
   assign rsp_chan.turns       = rsp_turns_ff;
   assign rsp_chan.net_angle   = rsp_total_ff;

   a_hit_enters_stage: assert property (@(posedge clock) disable iff (reset)
      accept && route.hit |=> s1_valid_ff)
      else $error("matched frame did not enter the update stage");

   a_cal_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_cal_ff |-> rsp_speed_ff == 16'sd0 && rsp_current_ff == 16'd0
                                    && rsp_hall_ff == 8'd0 && rsp_total_ff == 30'sd0)
      else $error("calibration beat carries measurements");

   a_fwd_after_write: assert property (@(posedge clock) disable iff (reset)
      $past(accept) && fwd_ff |-> $past(s1_adv))
      else $error("forwarded entry without a preceding write");

   a_write_moves_beat: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_valid_ff)
      else $error("slot write without a result beat");

endmodule

// ----- test/tb_motor_feedback_multiturn_tracker.sv -----
package mft_check_pkg;
   import mft_pkg::*;

   // Index with no register behind it; a write to it must change nothing.
   localparam logic [2:0] CSR_UNUSED = 3'd7;

   typedef struct {
      logic               bus;
      logic [ID_W-1:0]    frame_id;
      logic [15:0]        angle_raw;
      logic signed [15:0] speed_raw;
      logic [15:0]        current_raw;
      logic [7:0]         hall_byte;
   } feedback_frame_type;

   typedef struct {
      logic [SLOT_W-1:0]         slot;
      logic                      calibrating;
      logic [ANGLE_W-1:0]        angle;
      logic signed [15:0]        speed;
      logic [15:0]               current;
      logic [7:0]                hall;
      logic signed [TURN_W-1:0]  turns;
      logic signed [TOTAL_W-1:0] net_angle;
   } slot_report_type;

   class turn_tracker_scoreboard;
      logic [ID_W-1:0]    id_reg [7];
      logic [CNT_W-1:0]   frame_count [NUM_SLOTS];
      logic [ANGLE_W-1:0] prev_angle [NUM_SLOTS];
      logic [TURN_W-1:0]  turn_count [NUM_SLOTS];
      logic [ANGLE_W-1:0] zero_offset [NUM_SLOTS];
      slot_report_type    expected_reports [$];
      int                 mismatch_count;

      function new();
         int i;
         id_reg[CSR_CHASSIS_BASE] = CHASSIS_BASE_RST;
         id_reg[CSR_LIFT_A]       = LIFT_A_RST;
         id_reg[CSR_LIFT_B]       = LIFT_B_RST;
         id_reg[CSR_GRAB_A]       = GRAB_A_RST;
         id_reg[CSR_GRAB_B]       = GRAB_B_RST;
         id_reg[CSR_YAW]          = YAW_RST;
         id_reg[CSR_PITCH]        = PITCH_RST;
         for (i = 0; i < NUM_SLOTS; i++) begin
            frame_count[i] = '0;
            prev_angle[i]  = '0;
            turn_count[i]  = '0;
            zero_offset[i] = '0;
         end
         mismatch_count = 0;
      endfunction

      function void write_reg(logic [2:0] index, logic [ID_W-1:0] value);
         if (int'(index) <= int'(CSR_PITCH)) id_reg[index] = value;
      endfunction

      // Returns the slot a frame lands in, or -1. The first match wins.
      function int route(logic bus, logic [ID_W-1:0] id);
         int chassis_pos;
         chassis_pos = int'(id) - int'(id_reg[CSR_CHASSIS_BASE]);
         if (!bus) begin
            if (chassis_pos >= 0 && chassis_pos < CHASSIS_MOTORS) return chassis_pos;
            if (id == id_reg[CSR_LIFT_A]) return int'(SLOT_LIFT_A);
            if (id == id_reg[CSR_LIFT_B]) return int'(SLOT_LIFT_B);
         end else begin
            if (id == id_reg[CSR_GRAB_A]) return int'(SLOT_GRAB_A);
            if (id == id_reg[CSR_GRAB_B]) return int'(SLOT_GRAB_B);
            if (id == id_reg[CSR_YAW]) return int'(SLOT_YAW);
            if (id == id_reg[CSR_PITCH]) return int'(SLOT_PITCH);
         end
         return -1;
      endfunction

      // Bus and identifier that currently address a slot, as {bus, id}.
      function logic [ID_W:0] address_of(int slot_index);
         if (slot_index < CHASSIS_MOTORS)
            return {1'b0, id_reg[CSR_CHASSIS_BASE] + ID_W'(slot_index)};
         case (slot_index)
            int'(SLOT_LIFT_A): return {1'b0, id_reg[CSR_LIFT_A]};
            int'(SLOT_LIFT_B): return {1'b0, id_reg[CSR_LIFT_B]};
            int'(SLOT_GRAB_A): return {1'b1, id_reg[CSR_GRAB_A]};
            int'(SLOT_GRAB_B): return {1'b1, id_reg[CSR_GRAB_B]};
            int'(SLOT_YAW):    return {1'b1, id_reg[CSR_YAW]};
            default:           return {1'b1, id_reg[CSR_PITCH]};
         endcase
      endfunction

      function void predict_frame(feedback_frame_type f);
         int                 slot_index;
         int                 step;
         int                 total;
         logic [TURN_W-1:0]  t;
         slot_report_type    r;
         slot_index = route(f.bus, f.frame_id);
         if (slot_index < 0) return;
         r.slot  = SLOT_W'(slot_index);
         r.angle = f.angle_raw;
         if (frame_count[slot_index] <= CAL_FRAMES) begin
            frame_count[slot_index] = frame_count[slot_index] + 1'b1;
            prev_angle[slot_index]  = f.angle_raw;
            zero_offset[slot_index] = f.angle_raw;
            r.calibrating = 1'b1;
            r.speed       = '0;
            r.current     = '0;
            r.hall        = '0;
            r.turns       = turn_count[slot_index];
            r.net_angle   = '0;
         end else begin
            step = int'(f.angle_raw) - int'(prev_angle[slot_index]);
            t = turn_count[slot_index];
            if (step > WRAP_LIMIT) t = t - 1'b1;
            else if (step < -WRAP_LIMIT) t = t + 1'b1;
            turn_count[slot_index] = t;
            prev_angle[slot_index] = f.angle_raw;
            total = int'($signed(t)) * (1 << TURN_SHIFT) + int'(f.angle_raw)
                    - int'(zero_offset[slot_index]);
            r.calibrating = 1'b0;
            r.speed       = f.speed_raw;
            r.current     = f.current_raw;
            r.hall        = f.hall_byte;
            r.turns       = t;
            r.net_angle   = TOTAL_W'(total);
         end
         expected_reports.push_back(r);
      endfunction

      function int pending();
         return expected_reports.size();
      endfunction

      task report_mismatch(string msg);
         $display("mismatch: %s", msg);
         mismatch_count++;
      endtask

      task compare_field(string name, int slot_index, logic [31:0] got,
                         logic [31:0] want);
         if (got !== want)
            report_mismatch($sformatf("%s of slot %0d: got 0x%0h, expected 0x%0h",
                                      name, slot_index, got, want));
      endtask

      task check_report(slot_report_type got);
         slot_report_type want;
         if (expected_reports.size() == 0) begin
            report_mismatch($sformatf("result beat for slot %0d with no frame pending",
                                      got.slot));
            return;
         end
         want = expected_reports.pop_front();
         compare_field("slot", int'(want.slot), 32'(got.slot), 32'(want.slot));
         compare_field("calibrating", int'(want.slot), 32'(got.calibrating),
                       32'(want.calibrating));
         compare_field("angle", int'(want.slot), 32'(got.angle), 32'(want.angle));
         compare_field("speed", int'(want.slot), 32'(got.speed), 32'(want.speed));
         compare_field("current", int'(want.slot), 32'(got.current), 32'(want.current));
         compare_field("hall", int'(want.slot), 32'(got.hall), 32'(want.hall));
         compare_field("turns", int'(want.slot), 32'(got.turns), 32'(want.turns));
         compare_field("net_angle", int'(want.slot), 32'(got.net_angle),
                       32'(want.net_angle));
      endtask
   endclass

endpackage

module tb_motor_feedback_multiturn_tracker;
   import mft_pkg::*;
   import mft_check_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 300;
   localparam int SETTLE_CYCLES  = 6;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            csr_wr_en;
   logic [2:0]      csr_index;
   logic [ID_W-1:0] csr_wr_data;

   mft_req_if req_if ();
   mft_rsp_if rsp_if ();

   motor_feedback_multiturn_tracker u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if)
   );

   turn_tracker_scoreboard tracker = new();

   bit sender_idles   = 1'b0;
   bit receiver_idles = 1'b0;
   bit long_hold_req  = 1'b0;
   int stuck_cycles   = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Receiver: random stall bursts, plus one long hold-off on request.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end else begin
            if (stall_left == 0 && receiver_idles && $urandom_range(0, 5) == 0)
               stall_left = $urandom_range(1, 9);
            rsp_if.ready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
         end
      end
   end

   always @(posedge clock) begin
      slot_report_type observed;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         observed.slot        = rsp_if.slot;
         observed.calibrating = rsp_if.calibrating;
         observed.angle       = rsp_if.angle;
         observed.speed       = rsp_if.speed;
         observed.current     = rsp_if.current;
         observed.hall        = rsp_if.hall;
         observed.turns       = rsp_if.turns;
         observed.net_angle   = rsp_if.net_angle;
         tracker.check_report(observed);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
         if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h8000;
         3: return 16'h7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h80;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic feedback_frame_type make_frame(logic bus, logic [ID_W-1:0] id,
                                                     logic [15:0] ang, logic [15:0] spd,
                                                     logic [15:0] cur, logic [7:0] hall);
      feedback_frame_type f;
      f.bus         = bus;
      f.frame_id    = id;
      f.angle_raw   = ang;
      f.speed_raw   = spd;
      f.current_raw = cur;
      f.hall_byte   = hall;
      return f;
   endfunction

   // Matching frames aim at a slot under the current identifiers; once a slot
   // is past calibration its angle often steps to or just past the wrap threshold.
   function automatic feedback_frame_type random_frame(bit matching);
      feedback_frame_type f;
      int                 s;
      int                 target;
      f = make_frame(1'($urandom_range(0, 1)), ID_W'($urandom_range(0, 2047)),
                     pick_word(), pick_word(), pick_word(), pick_byte());
      if (matching) begin
         s = int'($urandom_range(0, NUM_SLOTS - 1));
         {f.bus, f.frame_id} = tracker.address_of(s);
         if (tracker.frame_count[s] > CAL_FRAMES) begin
            target = int'(tracker.prev_angle[s]);
            case ($urandom_range(0, 9))
               0: target = target + WRAP_LIMIT;
               1: target = target - WRAP_LIMIT;
               2: target = target + WRAP_LIMIT + 1;
               3: target = target - WRAP_LIMIT - 1;
               4, 5, 6: target = target + int'($urandom_range(0, 2 * WRAP_LIMIT))
                                 - WRAP_LIMIT;
               default: target = -1;
            endcase
            if (target >= 0 && target <= 65535) f.angle_raw = target[15:0];
         end
      end
      return f;
   endfunction

   task automatic send_frame(input feedback_frame_type f);
      int gap;
      gap = 0;
      if (sender_idles && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 9);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.bus         <= f.bus;
      req_if.frame_id    <= f.frame_id;
      req_if.angle_raw   <= f.angle_raw;
      req_if.speed_raw   <= f.speed_raw;
      req_if.current_raw <= f.current_raw;
      req_if.hall_byte   <= f.hall_byte;
      do @(posedge clock); while (!req_if.ready);
      tracker.predict_frame(f);
      @(negedge clock);
   endtask

   task automatic run_random_frames(input int count);
      int n;
      for (n = 0; n < count; n++) send_frame(random_frame($urandom_range(0, 99) < 85));
   endtask

   task automatic end_phase();
      req_if.valid <= 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [2:0] index, input logic [ID_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= value;
      tracker.write_reg(index, value);
      @(negedge clock);
   endtask

   task automatic program_ids(input logic [ID_W-1:0] base, lift_a, lift_b, grab_a,
                              grab_b, yaw, pitch, input bit poke_unused);
      write_csr(CSR_CHASSIS_BASE, base);
      write_csr(CSR_LIFT_A, lift_a);
      write_csr(CSR_LIFT_B, lift_b);
      write_csr(CSR_GRAB_A, grab_a);
      write_csr(CSR_GRAB_B, grab_b);
      write_csr(CSR_YAW, yaw);
      write_csr(CSR_PITCH, pitch);
      if (poke_unused) write_csr(CSR_UNUSED, ID_W'($urandom));
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      csr_wr_en          = 1'b0;
      csr_index          = CSR_CHASSIS_BASE;
      csr_wr_data        = '0;
      req_if.valid       = 1'b0;
      req_if.bus         = 1'b0;
      req_if.frame_id    = '0;
      req_if.angle_raw   = '0;
      req_if.speed_raw   = '0;
      req_if.current_raw = '0;
      req_if.hall_byte   = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed beats under the reset identifiers: every slot, near misses next to
      // the chassis range, lift b and grab b, and the extremes of the payload fields.
      send_frame(make_frame(1'b0, CHASSIS_BASE_RST, 16'h0000, 16'h8000, 16'h0000, 8'h00));
      send_frame(make_frame(1'b0, CHASSIS_BASE_RST + 11'd1, 16'hFFFF, 16'h7FFF, 16'hFFFF,
                            8'hFF));
      send_frame(make_frame(1'b0, CHASSIS_BASE_RST + 11'd2, 16'h8000, 16'hFFFF, 16'h8000,
                            8'h80));
      send_frame(make_frame(1'b0, CHASSIS_BASE_RST + 11'd3, 16'h7FFF, 16'h0001, 16'h7FFF,
                            8'h7F));
      send_frame(make_frame(1'b0, CHASSIS_BASE_RST - 11'd1, 16'h1234, 16'h0000, 16'h0001,
                            8'h01));
      send_frame(make_frame(1'b0, LIFT_A_RST, 16'hFFFF, 16'h8000, 16'hFFFF, 8'hFF));
      send_frame(make_frame(1'b0, LIFT_B_RST, 16'h0000, 16'h7FFF, 16'h0000, 8'h00));
      send_frame(make_frame(1'b0, LIFT_B_RST + 11'd1, 16'hAAAA, 16'h5555, 16'hAAAA,
                            8'h55));
      send_frame(make_frame(1'b0, 11'd0, 16'h5555, 16'hAAAA, 16'h5555, 8'hAA));
      send_frame(make_frame(1'b0, 11'd2047, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
      send_frame(make_frame(1'b1, GRAB_A_RST, 16'h0001, 16'h8000, 16'hFFFF, 8'hFF));
      send_frame(make_frame(1'b1, GRAB_B_RST, 16'hFFFE, 16'h7FFF, 16'h0000, 8'h00));
      send_frame(make_frame(1'b1, YAW_RST, 16'h1FFF, 16'h8001, 16'h8000, 8'h80));
      send_frame(make_frame(1'b1, PITCH_RST, 16'hE000, 16'h7FFE, 16'h7FFF, 8'h7F));
      send_frame(make_frame(1'b1, GRAB_B_RST + 11'd1, 16'h4321, 16'h0000, 16'h0000,
                            8'h00));
      send_frame(make_frame(1'b1, 11'd0, 16'h0000, 16'h0000, 16'h0000, 8'h00));
      send_frame(make_frame(1'b1, 11'd2047, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
      end_phase();

      // Lowest identifiers, with lift a hidden behind the chassis range and
      // grab b hidden behind grab a.
      program_ids(11'd0, 11'd0, 11'd2047, 11'd0, 11'd0, 11'd2047, 11'd1, 1'b1);
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      run_random_frames(240);
      end_phase();

      // Chassis range at the top of the identifier space; the receiver holds
      // off long enough for the input to back up.
      program_ids(11'd2044, 11'd2047, 11'd5, 11'd2047, 11'd2046, 11'd2045, 11'd2045, 1'b0);
      long_hold_req = 1'b1;
      run_random_frames(240);
      end_phase();

      program_ids(ID_W'($urandom_range(0, 2044)), ID_W'($urandom), ID_W'($urandom),
                  ID_W'($urandom), ID_W'($urandom), ID_W'($urandom), ID_W'($urandom),
                  1'b1);
      run_random_frames(240);
      end_phase();

      program_ids(CHASSIS_BASE_RST, LIFT_A_RST, LIFT_B_RST, GRAB_A_RST, GRAB_B_RST,
                  YAW_RST, PITCH_RST, 1'b0);
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      run_random_frames(230);
      end_phase();

      if (tracker.mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
